/* sv/assert_macros.svh */
// Assertion helpers used by the checker.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, off while reset is low.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Condition that must never be seen at a rising edge.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  `ASSERT_CLK(lbl, clk, rstn, !(cond), msg)

`endif

/* sv/irpw_pkg.sv */
// Shared types, constants and the window compare for the IR pulse-width receiver.
// No dependencies.
package irpw_pkg;

  localparam int unsigned FrameEntries = 18;
  localparam int unsigned StoreDepth   = 32;

  localparam int unsigned TickW  = 8;
  localparam int unsigned WinW   = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned PayW   = 7;
  localparam int unsigned ErrW   = 3;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_GUARD      = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_HEADER_WIN = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_SPACE_WIN  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_ONE_WIN    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_ZERO_WIN   = 3'd4;

  localparam logic [TickW-1:0] GUARD_RST = 8'd40;
  localparam logic [WinW-1:0]  WIN_RST   = 16'hFF00;

  // error codes
  localparam logic [ErrW-1:0] ERR_OK        = 3'd0;
  localparam logic [ErrW-1:0] ERR_LENGTH    = 3'd1;
  localparam logic [ErrW-1:0] ERR_GAP       = 3'd2;
  localparam logic [ErrW-1:0] ERR_HEADER    = 3'd3;
  localparam logic [ErrW-1:0] ERR_BIT_MARK  = 3'd4;
  localparam logic [ErrW-1:0] ERR_SPACE     = 3'd5;
  localparam logic [ErrW-1:0] ERR_PARITY    = 3'd6;

  typedef struct packed {
    logic [TickW-1:0] guard;
    logic [WinW-1:0]  header_win;
    logic [WinW-1:0]  space_win;
    logic [WinW-1:0]  one_win;
    logic [WinW-1:0]  zero_win;
  } cfg_t;

  typedef struct packed {
    logic            frame_ok;
    logic [PayW-1:0] payload;
    logic [ErrW-1:0] error_code;
  } result_t;

  // low byte is the minimum, high byte the maximum, both inclusive
  function automatic logic in_window(logic [TickW-1:0] v, logic [WinW-1:0] win);
    return (v >= win[TickW-1:0]) && (v <= win[WinW-1:TickW]);
  endfunction

endpackage

/* sv/irpw_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module irpw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/irpw_capture.sv */
// Tick-level capture: times gap, marks and spaces and writes each duration to the store.
// Depends on irpw_pkg.
module irpw_capture #(
  parameter int unsigned STORE_DEPTH = irpw_pkg::StoreDepth
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             accept_i,
  input  logic                             ir_mark_i,
  input  logic [irpw_pkg::TickW-1:0]       guard_i,
  output logic                             wr_en_o,
  output logic [$clog2(STORE_DEPTH)-1:0]   wr_addr_o,
  output logic [irpw_pkg::TickW-1:0]       wr_data_o,
  output logic                             frame_end_o,
  output logic [$clog2(STORE_DEPTH+1)-1:0] frame_count_o
);

  localparam int unsigned AW = $clog2(STORE_DEPTH);
  localparam int unsigned CW = $clog2(STORE_DEPTH + 1);
  localparam int unsigned TW = irpw_pkg::TickW;

  typedef enum logic [1:0] {
    CAP_IDLE,
    CAP_MARK,
    CAP_SPACE
  } cap_state_e;

  cap_state_e    state_q, state_d;
  logic [TW-1:0] tick_q, tick_d, tick_inc;
  logic [CW-1:0] count_q, count_d, count_next;
  logic          rec;
  logic [TW-1:0] rec_val;
  logic          stop;

  assign tick_inc = (tick_q == {TW{1'b1}}) ? tick_q : tick_q + TW'(1);

  always_comb begin
    state_d = state_q;
    tick_d  = tick_inc;
    rec     = 1'b0;
    rec_val = tick_inc;
    stop    = 1'b0;
    case (state_q)
      CAP_IDLE: begin
        if (tick_inc >= guard_i) begin
          // gap long enough: hold at guard
          tick_d = guard_i;
          if (ir_mark_i) begin
            rec     = 1'b1;
            rec_val = guard_i;
            tick_d  = '0;
            state_d = CAP_MARK;
          end
        end else if (ir_mark_i) begin
          tick_d = '0;
        end
      end
      CAP_MARK: begin
        if (!ir_mark_i) begin
          rec     = 1'b1;
          tick_d  = '0;
          state_d = CAP_SPACE;
        end
      end
      default: begin
        if (ir_mark_i) begin
          rec     = 1'b1;
          tick_d  = '0;
          state_d = CAP_MARK;
        end else if (tick_inc > guard_i) begin
          stop = 1'b1;
        end
      end
    endcase

    count_next = count_q + CW'(rec);
    if (count_next >= CW'(STORE_DEPTH)) begin
      stop = 1'b1;
    end

    count_d = count_next;
    if (stop) begin
      state_d = CAP_IDLE;
      tick_d  = '0;
      count_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CAP_IDLE;
      tick_q  <= '0;
      count_q <= '0;
    end else if (accept_i) begin
      state_q <= state_d;
      tick_q  <= tick_d;
      count_q <= count_d;
    end
  end

  assign wr_en_o       = accept_i && rec;
  assign wr_addr_o     = AW'(count_q);
  assign wr_data_o     = rec_val;
  assign frame_end_o   = accept_i && stop;
  assign frame_count_o = count_next;

endmodule

/* sv/irpw_decode.sv */
// Frame decode sequencer: walks the stored durations through one shared window compare.
// Depends on irpw_pkg.
module irpw_decode #(
  parameter int unsigned FRAME_ENTRIES = irpw_pkg::FrameEntries,
  parameter int unsigned STORE_DEPTH   = irpw_pkg::StoreDepth
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [$clog2(STORE_DEPTH+1)-1:0] count_i,
  input  irpw_pkg::cfg_t                   cfg_i,
  output logic [$clog2(STORE_DEPTH)-1:0]   rd_addr_o,
  input  logic [irpw_pkg::TickW-1:0]       rd_data_i,
  output logic                             busy_o,
  output logic                             res_valid_o,
  input  logic                             res_ready_i,
  output irpw_pkg::result_t                res_o
);

  localparam int unsigned AW = $clog2(STORE_DEPTH);
  localparam int unsigned CW = $clog2(STORE_DEPTH + 1);
  localparam int unsigned PW = $clog2(FRAME_ENTRIES + 1);
  localparam int unsigned TW = irpw_pkg::TickW;

  typedef enum logic [2:0] {
    D_IDLE,
    D_READ,
    D_EVAL,
    D_ZERO,
    D_DONE
  } dec_state_e;

  dec_state_e               state_q, state_d;
  logic [PW-1:0]            idx_q, idx_d, nidx;
  logic [TW-1:0]            bits_q, bits_d;
  logic                     parity_q, parity_d;
  irpw_pkg::result_t        res_q, res_d;
  logic [irpw_pkg::WinW-1:0] win;
  logic                     hit;
  logic                     adv;

  // shared compare: window chosen by entry position and phase
  always_comb begin
    if (idx_q == PW'(0)) begin
      win = {{TW{1'b1}}, cfg_i.guard};
    end else if (idx_q == PW'(1)) begin
      win = cfg_i.header_win;
    end else if (!idx_q[0]) begin
      win = cfg_i.space_win;
    end else if (state_q == D_ZERO) begin
      win = cfg_i.zero_win;
    end else begin
      win = cfg_i.one_win;
    end
  end

  assign hit  = irpw_pkg::in_window(rd_data_i, win);
  assign nidx = idx_q + PW'(1);

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    bits_d   = bits_q;
    parity_d = parity_q;
    res_d    = res_q;
    adv      = 1'b0;
    case (state_q)
      D_IDLE: begin
        if (start_i) begin
          idx_d    = '0;
          bits_d   = '0;
          parity_d = 1'b1;
          if (count_i != CW'(FRAME_ENTRIES)) begin
            res_d   = '{frame_ok: 1'b0, payload: '0, error_code: irpw_pkg::ERR_LENGTH};
            state_d = D_DONE;
          end else begin
            state_d = D_READ;
          end
        end
      end
      D_READ: begin
        state_d = D_EVAL;
      end
      D_EVAL: begin
        if (idx_q == PW'(0)) begin
          if (!hit) begin
            res_d   = '{frame_ok: 1'b0, payload: '0, error_code: irpw_pkg::ERR_GAP};
            state_d = D_DONE;
          end else begin
            idx_d   = nidx;
            state_d = D_READ;
          end
        end else if (idx_q == PW'(1)) begin
          if (!hit) begin
            res_d   = '{frame_ok: 1'b0, payload: '0, error_code: irpw_pkg::ERR_HEADER};
            state_d = D_DONE;
          end else begin
            adv = 1'b1;
          end
        end else if (!idx_q[0]) begin
          if (!hit) begin
            res_d   = '{frame_ok: 1'b0, payload: '0, error_code: irpw_pkg::ERR_SPACE};
            state_d = D_DONE;
          end else begin
            idx_d   = nidx;
            state_d = D_READ;
          end
        end else if (hit) begin
          bits_d   = {bits_q[TW-2:0], 1'b1};
          parity_d = ~parity_q;
          adv      = 1'b1;
        end else begin
          state_d = D_ZERO;
        end
      end
      D_ZERO: begin
        if (hit) begin
          bits_d = {bits_q[TW-2:0], 1'b0};
          adv    = 1'b1;
        end else begin
          res_d   = '{frame_ok: 1'b0, payload: '0, error_code: irpw_pkg::ERR_BIT_MARK};
          state_d = D_DONE;
        end
      end
      D_DONE: begin
        if (res_ready_i) begin
          state_d = D_IDLE;
        end
      end
      default: begin
        state_d = D_IDLE;
      end
    endcase

    // next pair starts at nidx; the walk ends once no full pair is left
    if (adv) begin
      if (nidx >= PW'(FRAME_ENTRIES - 1)) begin
        state_d = D_DONE;
        if (nidx != PW'(FRAME_ENTRIES)) begin
          res_d = '{frame_ok: 1'b0, payload: '0, error_code: irpw_pkg::ERR_SPACE};
        end else if (parity_d) begin
          res_d = '{frame_ok: 1'b0, payload: '0, error_code: irpw_pkg::ERR_PARITY};
        end else begin
          res_d = '{frame_ok: 1'b1, payload: bits_d[TW-1:1],
                    error_code: irpw_pkg::ERR_OK};
        end
      end else begin
        idx_d   = nidx;
        state_d = D_READ;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    bits_q   <= bits_d;
    parity_q <= parity_d;
    res_q    <= res_d;
  end

  assign rd_addr_o   = AW'(idx_q);
  assign busy_o      = (state_q != D_IDLE);
  assign res_valid_o = (state_q == D_DONE);
  assign res_o       = res_q;

endmodule

/* sv/ir_pulse_width_frame_receiver.sv */
// Top level of the IR pulse-width frame receiver: config registers, duration store,
// output register. Depends on irpw_pkg, irpw_ram, irpw_capture, irpw_decode.
//
// One beat on the input is one sampled receiver level. An ordinary tick does not
// raise in_stall_o. A tick that ends a frame (a space longer than guard_ticks, or a
// full duration store) starts the decode walk: each stored entry is read from the
// duration RAM, then passed through the single window comparator, and a bit mark
// that misses the one window is compared once more against the zero window. A frame
// of the wrong length goes straight to the result. in_stall_o is high for the whole
// walk and until the result has moved into the output register. The result sits in
// that register until taken, and ticks keep flowing meanwhile. The store needs no
// clearing after reset.
module ir_pulse_width_frame_receiver #(
  parameter int unsigned FRAME_ENTRIES = irpw_pkg::FrameEntries,
  parameter int unsigned STORE_DEPTH   = irpw_pkg::StoreDepth
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            ir_mark_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            frame_ok_o,
  output logic [irpw_pkg::PayW-1:0]       payload_o,
  output logic [irpw_pkg::ErrW-1:0]       error_code_o,
  input  logic                            cfg_we_i,
  input  logic [irpw_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [irpw_pkg::WinW-1:0]       cfg_wdata_i
);

  localparam int unsigned AW = $clog2(STORE_DEPTH);
  localparam int unsigned CW = $clog2(STORE_DEPTH + 1);
  localparam int unsigned TW = irpw_pkg::TickW;

  irpw_pkg::cfg_t    cfg_q;
  logic              accept;
  logic              wr_en;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [TW-1:0]     wr_data, rd_data;
  logic              frame_end;
  logic [CW-1:0]     frame_count;
  logic              dec_busy;
  logic              res_valid, res_load;
  irpw_pkg::result_t dec_res, out_q;
  logic              out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.guard      <= irpw_pkg::GUARD_RST;
      cfg_q.header_win <= irpw_pkg::WIN_RST;
      cfg_q.space_win  <= irpw_pkg::WIN_RST;
      cfg_q.one_win    <= irpw_pkg::WIN_RST;
      cfg_q.zero_win   <= irpw_pkg::WIN_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        irpw_pkg::CFG_GUARD:      cfg_q.guard      <= cfg_wdata_i[TW-1:0];
        irpw_pkg::CFG_HEADER_WIN: cfg_q.header_win <= cfg_wdata_i;
        irpw_pkg::CFG_SPACE_WIN:  cfg_q.space_win  <= cfg_wdata_i;
        irpw_pkg::CFG_ONE_WIN:    cfg_q.one_win    <= cfg_wdata_i;
        irpw_pkg::CFG_ZERO_WIN:   cfg_q.zero_win   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = dec_busy;
  assign accept     = in_valid_i && !dec_busy;

  irpw_capture #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_capture (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .ir_mark_i    (ir_mark_i),
    .guard_i      (cfg_q.guard),
    .wr_en_o      (wr_en),
    .wr_addr_o    (wr_addr),
    .wr_data_o    (wr_data),
    .frame_end_o  (frame_end),
    .frame_count_o(frame_count)
  );

  irpw_ram #(
    .WIDTH(TW),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(wr_addr),
    .wdata_i(wr_data),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  irpw_decode #(
    .FRAME_ENTRIES(FRAME_ENTRIES),
    .STORE_DEPTH  (STORE_DEPTH)
  ) u_decode (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (frame_end),
    .count_i    (frame_count),
    .cfg_i      (cfg_q),
    .rd_addr_o  (rd_addr),
    .rd_data_i  (rd_data),
    .busy_o     (dec_busy),
    .res_valid_o(res_valid),
    .res_ready_i(res_load),
    .res_o      (dec_res)
  );

  // output register frees the decoder as soon as it is empty or being drained
  assign res_load    = res_valid && (!out_valid_q || !out_stall_i);
  assign out_valid_d = res_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_q <= dec_res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign frame_ok_o   = out_q.frame_ok;
  assign payload_o    = out_q.payload;
  assign error_code_o = out_q.error_code;

endmodule

/* sv/irpw_checker.sv */
// Port-level checks for the IR pulse-width frame receiver, bound to the top level.
// Depends on irpw_pkg and assert_macros.svh.
`include "assert_macros.svh"

module irpw_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic                         frame_ok_o,
  input logic [irpw_pkg::PayW-1:0]    payload_o,
  input logic [irpw_pkg::ErrW-1:0]    error_code_o
);

  `ASSERT_CLK(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(payload_o) && $stable(error_code_o) && $stable(frame_ok_o), "stalled result beat changed")

  `ASSERT_CLK(a_ok_code, clk_i, rst_ni, out_valid_o && frame_ok_o |-> error_code_o == irpw_pkg::ERR_OK, "ok beat with an error code")

  `ASSERT_CLK(a_err_payload, clk_i, rst_ni, out_valid_o && !frame_ok_o |-> payload_o == '0 && error_code_o != irpw_pkg::ERR_OK, "error beat with payload or ok code")

  // a result beat appears only after a tick that ended a frame, so stall precedes it
  `ASSERT_CLK(a_new_result, clk_i, rst_ni, $rose(out_valid_o) |-> $past(in_stall_o), "result beat without a decode walk")

  `ASSERT_NEVER(a_code_range, clk_i, rst_ni, out_valid_o && error_code_o == 3'd7, "undefined error code")

endmodule

bind ir_pulse_width_frame_receiver irpw_checker u_irpw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .frame_ok_o  (frame_ok_o),
  .payload_o   (payload_o),
  .error_code_o(error_code_o)
);

/* tb/sv/ir_pulse_width_frame_receiver_tb.sv */
// Self-checking testbench for ir_pulse_width_frame_receiver: a cycle-level frame predictor
// in a scoreboard class checks every decoded frame. Depends on irpw_pkg and the RTL only.
module ir_pulse_width_frame_receiver_tb;
  import irpw_pkg::*;

  localparam int unsigned CycleLimit  = 400_000;
  localparam int unsigned DrainCycles = 64;
  localparam logic [WinW-1:0] WinShut = 16'h00FF;  // min above max: accepts nothing

  typedef enum logic [1:0] {CAP_IDLE, CAP_MARK, CAP_SPACE, CAP_DONE} cap_state_e;

  class frame_scoreboard;
    cfg_t                 regs;
    cap_state_e           cap;
    logic [TickW-1:0]     ticks;
    int unsigned          n_durs;
    logic [TickW-1:0]     durs [StoreDepth];
    result_t              expected_frames [$];
    int unsigned          mismatches;

    function new();
      regs.guard      = GUARD_RST;
      regs.header_win = WIN_RST;
      regs.space_win  = WIN_RST;
      regs.one_win    = WIN_RST;
      regs.zero_win   = WIN_RST;
      cap             = CAP_IDLE;
      ticks           = '0;
      n_durs          = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [WinW-1:0] data);
      case (idx)
        CFG_GUARD:      regs.guard      = data[TickW-1:0];
        CFG_HEADER_WIN: regs.header_win = data;
        CFG_SPACE_WIN:  regs.space_win  = data;
        CFG_ONE_WIN:    regs.one_win    = data;
        CFG_ZERO_WIN:   regs.zero_win   = data;
        default: ;
      endcase
    endfunction

    function bit in_range(logic [TickW-1:0] v, logic [WinW-1:0] win);
      return v >= win[TickW-1:0] && v <= win[WinW-1:TickW];
    endfunction

    function void push_dur(logic [TickW-1:0] v);
      if (n_durs < StoreDepth) durs[n_durs] = v;
      n_durs++;
    endfunction

    function logic [ErrW-1:0] decode_frame(output logic [PayW-1:0] pay);
      int unsigned pos;
      logic        par;
      logic [7:0]  bits;
      pay  = '0;
      par  = 1'b1;
      bits = '0;
      if (n_durs != FrameEntries) return ERR_LENGTH;
      if (durs[0] < regs.guard) return ERR_GAP;
      if (!in_range(durs[1], regs.header_win)) return ERR_HEADER;
      pos = 2;
      while (pos + 1 < n_durs) begin
        if (!in_range(durs[pos], regs.space_win)) break;
        pos++;
        // one window has priority over zero window
        if (in_range(durs[pos], regs.one_win)) begin
          bits = {bits[6:0], 1'b1};
          par  = ~par;
        end else if (in_range(durs[pos], regs.zero_win)) begin
          bits = {bits[6:0], 1'b0};
        end else begin
          return ERR_BIT_MARK;
        end
        pos++;
      end
      if (pos != FrameEntries) return ERR_SPACE;
      if (par) return ERR_PARITY;
      pay = bits[7:1];
      return ERR_OK;
    endfunction

    // one accepted beat: advance capture, queue a frame result when capture stops
    function void note_tick(logic mark);
      logic [PayW-1:0] pay;
      logic [ErrW-1:0] err;
      result_t         r;
      if (ticks != 8'hFF) ticks++;
      case (cap)
        CAP_IDLE: begin
          if (ticks >= regs.guard) begin
            ticks = regs.guard;
            if (mark) begin
              push_dur(ticks);
              ticks = '0;
              cap   = CAP_MARK;
            end
          end else if (mark) begin
            ticks = '0;
          end
        end
        CAP_MARK: begin
          if (!mark) begin
            push_dur(ticks);
            ticks = '0;
            cap   = CAP_SPACE;
          end
        end
        default: begin
          if (mark) begin
            push_dur(ticks);
            ticks = '0;
            cap   = CAP_MARK;
          end else if (ticks > regs.guard) begin
            cap = CAP_DONE;
          end
        end
      endcase
      if (n_durs >= StoreDepth) cap = CAP_DONE;
      if (cap == CAP_DONE) begin
        err          = decode_frame(pay);
        r.frame_ok   = (err == ERR_OK);
        r.payload    = pay;
        r.error_code = err;
        expected_frames.push_back(r);
        cap    = CAP_IDLE;
        ticks  = '0;
        n_durs = 0;
      end
    endfunction

    function void flag(string why, result_t want, result_t got);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t %s: expected ok=%0b payload=%h err=%0d, got ok=%0b payload=%h err=%0d",
                 $time, why, want.frame_ok, want.payload, want.error_code,
                 got.frame_ok, got.payload, got.error_code);
    endfunction

    function void check_frame(result_t got);
      result_t want;
      if (expected_frames.size() == 0) begin
        flag("frame with nothing pending", '0, got);
        return;
      end
      want = expected_frames.pop_front();
      if (got.frame_ok !== want.frame_ok || got.payload !== want.payload ||
          got.error_code !== want.error_code)
        flag("frame mismatch", want, got);
    endfunction

    function int unsigned pending();
      return expected_frames.size();
    endfunction

    function bit all_clear();
      if (expected_frames.size() != 0) begin
        mismatches++;
        $display("%0d expected frames never arrived", expected_frames.size());
      end
      return mismatches == 0;
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic                ir_mark_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic                frame_ok_o;
  logic [PayW-1:0]     payload_o;
  logic [ErrW-1:0]     error_code_o;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [WinW-1:0]     cfg_wdata_i;

  frame_scoreboard sb = new();

  bit          calm;         // no idling on either side
  int unsigned hold_cycles;  // receiver hold-off request
  int unsigned beats_sent;
  int unsigned run_q [$];    // alternating level runs, starting with space

  ir_pulse_width_frame_receiver i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .ir_mark_i,
    .out_valid_o,
    .out_stall_i,
    .frame_ok_o,
    .payload_o,
    .error_code_o,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_wdata_i
  );

  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    result_t got;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_tick(ir_mark_i);
      if (out_valid_o && !out_stall_i) begin
        got.frame_ok   = frame_ok_o;
        got.payload    = payload_o;
        got.error_code = error_code_o;
        sb.check_frame(got);
      end
    end
  end

  // receiver: random stalls, plus long hold-offs on request
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold_cycles) @(negedge clk_i);
        hold_cycles = 0;
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= !calm && ($urandom_range(99) < 16);
      end
    end
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // called at a falling edge, returns at the falling edge after the beat is taken
  task automatic send_tick(input logic mark);
    while (!calm && $urandom_range(99) < 16) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    ir_mark_i  <= mark;
    do @(posedge clk_i); while (in_stall_o);
    beats_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_run(input logic level, input int unsigned n);
    repeat (n) send_tick(level);
  endtask

  task automatic add_run(input int unsigned n);
    run_q.push_back(n);
  endtask

  task automatic play_runs();
    logic level;
    level = 1'b0;
    foreach (run_q[k]) begin
      send_run(level, run_q[k]);
      level = ~level;
    end
    run_q.delete();
  endtask

  // gap, header, then pairs of space and bit mark (one = 4 ticks, zero = 2 ticks)
  task automatic directed_frame(input int unsigned hdr, input int unsigned sp,
                                input logic [7:0] word, input int unsigned npairs,
                                input int unsigned odd_mark, input int unsigned early);
    int unsigned i;
    if (early != 0) begin
      add_run(early);
      add_run(2);
    end
    add_run(sb.regs.guard + 1);
    add_run(hdr);
    for (i = 0; i < npairs; i++) begin
      add_run(sp);
      if (odd_mark != 0 && i == 3) add_run(odd_mark);
      else add_run(word[7 - (i % 8)] ? 4 : 2);
    end
    add_run(sb.regs.guard + 3);
    play_runs();
  endtask

  // no ending space: the frame stops when the duration store fills
  task automatic full_store_frame(input int unsigned gap, input int unsigned hdr);
    int unsigned i;
    add_run(gap);
    add_run(hdr);
    for (i = 1; i < StoreDepth - 1; i++) add_run($urandom_range(6, 1));
    add_run(3);
    play_runs();
  endtask

  function automatic int unsigned pick_in(logic [WinW-1:0] win, int unsigned limit);
    int unsigned lo, hi;
    lo = (win[TickW-1:0] == 0) ? 1 : win[TickW-1:0];
    hi = (win[WinW-1:TickW] > limit) ? limit : win[WinW-1:TickW];
    if (lo <= hi) return $urandom_range(hi, lo);
    return $urandom_range(limit, 1);
  endfunction

  task automatic random_frame();
    int unsigned guard, sp_max, npairs, i, roll;
    logic [7:0]  word;
    logic        bit_val;
    guard  = sb.regs.guard;
    sp_max = guard + 1;  // a longer space would end the frame
    npairs = ($urandom_range(99) < 12) ? $urandom_range(16, 0) : 8;
    word[7:1] = 7'($urandom);
    word[0]   = ~^word[7:1];
    if ($urandom_range(99) < 10) word[0] = ~word[0];
    // a mark before the gap is long enough
    if (guard > 1 && $urandom_range(99) < 10) begin
      add_run($urandom_range(guard - 1, 1));
      add_run($urandom_range(3, 1));
    end
    add_run(guard + $urandom_range(4, 1));
    if ($urandom_range(99) < 8) add_run($urandom_range(40, 1));
    else add_run(pick_in(sb.regs.header_win, 40));
    for (i = 0; i < npairs; i++) begin
      roll = $urandom_range(99);
      if (roll < 4) add_run(sp_max + $urandom_range(3, 1));
      else if (roll < 10) add_run($urandom_range(sp_max, 1));
      else add_run(pick_in(sb.regs.space_win, sp_max));
      bit_val = (i < 8) ? word[7 - i] : 1'($urandom);
      if ($urandom_range(99) < 6) add_run($urandom_range(24, 1));
      else add_run(pick_in(bit_val ? sb.regs.one_win : sb.regs.zero_win, 24));
    end
    add_run(guard + 2 + $urandom_range(4, 0));
    play_runs();
  endtask

  task automatic put_reg(input logic [CfgIdxW-1:0] idx, input logic [WinW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    sb.set_reg(idx, data);
    @(negedge clk_i);
  endtask

  task automatic apply_setup(input cfg_t c);
    put_reg(CFG_GUARD, {8'h00, c.guard});
    put_reg(CFG_HEADER_WIN, c.header_win);
    put_reg(CFG_SPACE_WIN, c.space_win);
    put_reg(CFG_ONE_WIN, c.one_win);
    put_reg(CFG_ZERO_WIN, c.zero_win);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [WinW-1:0] random_window(int unsigned lo_max, int unsigned span);
    logic [TickW-1:0] lo, hi;
    int unsigned      roll;
    roll = $urandom_range(99);
    lo   = TickW'($urandom_range(lo_max, 1));
    hi   = lo + TickW'($urandom_range(span, 0));
    if (roll < 6) return WIN_RST;
    if (roll < 12) return WinShut;
    return {hi, lo};
  endfunction

  task automatic random_setup();
    cfg_t c;
    c.guard      = TickW'($urandom_range(16, 2));
    c.header_win = random_window(12, 8);
    c.space_win  = random_window(2, 3);
    c.one_win    = random_window(7, 3);
    c.zero_win   = random_window(3, 2);
    apply_setup(c);
  endtask

  // drop valid, wait for every pending frame and the decode latency
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  initial begin
    cfg_t        c;
    int unsigned phase, beats_at_start;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    ir_mark_i   = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = CFG_GUARD;
    cfg_wdata_i = '0;
    calm        = 1'b0;
    hold_cycles = 0;
    beats_sent  = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // registers at reset: every window open
    directed_frame(8, 2, 8'hFE, 8, 0, 0);
    settle();

    c = '{guard: 8'd10, header_win: 16'h0906, space_win: 16'h0301,
          one_win: 16'h0504, zero_win: 16'h0201};
    apply_setup(c);
    directed_frame(7, 2, 8'hFE, 8, 0, 0);
    directed_frame(7, 3, 8'h01, 8, 0, 0);
    directed_frame(7, 1, 8'h00, 8, 0, 0);   // even parity
    directed_frame(6, 2, 8'hA4, 8, 0, 0);   // header at its minimum
    directed_frame(9, 2, 8'h01, 8, 0, 0);   // header at its maximum
    directed_frame(10, 2, 8'h01, 8, 0, 0);
    directed_frame(5, 2, 8'h01, 8, 0, 0);
    directed_frame(7, 2, 8'h01, 8, 3, 0);   // mark in neither bit window
    directed_frame(7, 4, 8'h01, 8, 0, 0);   // bit space out of window
    directed_frame(7, 2, 8'h01, 3, 0, 0);
    directed_frame(7, 2, 8'h01, 10, 0, 0);
    directed_frame(7, 2, 8'h2C, 8, 0, 4);   // early mark restarts the gap
    full_store_frame(12, 5);
    settle();

    // saturated header mark, empty one window
    c = sb.regs;
    c.guard      = 8'd20;
    c.header_win = 16'hFFFF;
    c.one_win    = WinShut;
    apply_setup(c);
    directed_frame(300, 2, 8'h00, 8, 0, 0);
    directed_frame(254, 2, 8'h00, 8, 0, 0);
    directed_frame(300, 2, 8'h01, 8, 0, 0);
    settle();

    // zero guard: every space past one tick ends the frame
    c = '{guard: 8'd0, header_win: WIN_RST, space_win: 16'h0101,
          one_win: 16'h0302, zero_win: 16'h0101};
    apply_setup(c);
    repeat (6) random_frame();
    settle();

    // full guard: spaces never end a frame, only a full store does
    c = sb.regs;
    c.guard    = 8'hFF;
    c.zero_win = 16'h0000;
    apply_setup(c);
    full_store_frame(260, 300);
    full_store_frame(260, 3);
    settle();

    beats_at_start = beats_sent;
    phase = 0;
    while (beats_sent - beats_at_start < 1600 || phase < 3) begin
      random_setup();
      calm = (phase == 2);
      if (phase == 1) hold_cycles = 900;  // lets the output back up into the input
      repeat (6) random_frame();
      settle();
      phase++;
    end

    if (sb.all_clear())
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+sv
sv/irpw_pkg.sv
sv/irpw_ram.sv
sv/irpw_capture.sv
sv/irpw_decode.sv
sv/ir_pulse_width_frame_receiver.sv
sv/irpw_checker.sv
tb/sv/ir_pulse_width_frame_receiver_tb.sv
